// ===== src/wqdm_pkg.sv =====
// Shared types and constants of the watched task queue delay monitor.
// No dependencies; imported by every module of the block.
package wqdm_pkg;

    localparam int unsigned WATCH_DEPTH_DEF   = 512;
    localparam int unsigned PENDING_DEPTH_DEF = 512;

    localparam int unsigned ID_W   = 22;
    localparam int unsigned TS_W   = 64;
    localparam int unsigned MODE_W = 2;
    localparam int unsigned ST_W   = 3;

    localparam logic [TS_W-1:0] DISCARD_RESET = 64'd1000000000;
    localparam logic [TS_W-1:0] LATE_RESET    = 64'd4000000;

    // request modes
    localparam logic [MODE_W-1:0] MODE_ADD    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_WAKE   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SWITCH = 2'd3;

    // result status codes
    localparam logic [ST_W-1:0] ST_IGNORED   = 3'd0;
    localparam logic [ST_W-1:0] ST_WAKE      = 3'd1;
    localparam logic [ST_W-1:0] ST_COUNTED   = 3'd2;
    localparam logic [ST_W-1:0] ST_DISCARDED = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_ADDED     = 3'd5;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd6;
    localparam logic [ST_W-1:0] ST_ABSENT    = 3'd7;

    // configuration register indexes
    localparam logic CFG_DISCARD = 1'b0;
    localparam logic CFG_LATE    = 1'b1;

    typedef struct packed {
        logic clr;     // clearing pass step
        logic accept;  // capture request, arm scan
        logic scan;    // table scan step
        logic exec;    // apply table update
        logic finish;  // update statistics, load result
    } t_cmd;

    typedef struct packed {
        logic clr_done;
        logic scan_done;
        logic out_free;
    } t_sts;

endpackage

// ===== src/wqdm_ctrl.sv =====
// Controller state machine of the queue delay monitor.
// Depends on wqdm_pkg; drives commands to wqdm_dp.
module wqdm_ctrl
    import wqdm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLR  = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_EXEC = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    logic [2:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_done) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) n_state = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_FIN;
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

// ===== src/wqdm_dp.sv =====
// Datapath of the queue delay monitor: both tables, scan, statistics, result register.
// Depends on wqdm_pkg; sequenced by wqdm_ctrl.
module wqdm_dp
    import wqdm_pkg::*;
#(
    parameter int unsigned WATCH_DEPTH   = WATCH_DEPTH_DEF,
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic [TS_W-1:0]   i_timestamp_ns,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [TS_W-1:0]   i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [TS_W-1:0]   o_delay_ns,
    output logic [TS_W-1:0]   o_total_delay_ns,
    output logic [TS_W-1:0]   o_sample_count,
    output logic [TS_W-1:0]   o_peak_delay_ns,
    output logic [TS_W-1:0]   o_late_count
);

    localparam int unsigned MAXD = (WATCH_DEPTH > PENDING_DEPTH) ? WATCH_DEPTH : PENDING_DEPTH;
    localparam int unsigned CW   = $clog2(MAXD + 1);
    localparam int unsigned WAW  = (WATCH_DEPTH > 1) ? $clog2(WATCH_DEPTH) : 1;
    localparam int unsigned PAW  = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int unsigned WEW  = 1 + ID_W;
    localparam int unsigned PEW  = 1 + ID_W + TS_W;

    // entry layouts: {valid, id} and {valid, id, wake time}
    logic [WEW-1:0] watch_mem [WATCH_DEPTH];
    logic [PEW-1:0] pend_mem  [PENDING_DEPTH];

    logic [TS_W-1:0]   r_discard, r_late;
    logic [MODE_W-1:0] r_mode;
    logic [ID_W-1:0]   r_id;
    logic [TS_W-1:0]   r_ts;
    logic [CW-1:0]     r_cnt;

    logic           r_wv, r_pv;
    logic [WAW-1:0] r_wra;
    logic [PAW-1:0] r_pra;
    logic [WEW-1:0] r_wq;
    logic [PEW-1:0] r_pq;

    logic            r_w_hit, r_w_free, r_p_hit, r_p_free;
    logic [WAW-1:0]  r_w_hidx, r_w_fidx;
    logic [PAW-1:0]  r_p_hidx, r_p_fidx;
    logic [TS_W-1:0] r_p_time;

    logic [ST_W-1:0] r_st;
    logic [TS_W-1:0] r_delay;
    logic [TS_W-1:0] r_sum, r_samples, r_peak, r_lates;

    logic            r_o_valid;
    logic [ST_W-1:0] r_o_status;
    logic [TS_W-1:0] r_o_delay, r_o_sum, r_o_samples, r_o_peak, r_o_lates;

    logic w_rd, p_rd;
    logic w_we, p_we;
    logic [WAW-1:0] w_wa;
    logic [PAW-1:0] p_wa;
    logic [WEW-1:0] w_wd;
    logic [PEW-1:0] p_wd;
    logic [ST_W-1:0]  n_st;
    logic [TS_W-1:0]  n_delay;
    logic w_match, w_empty, p_match, p_empty;
    logic counted;

    assign w_rd = i_cmd.scan && (r_cnt < CW'(WATCH_DEPTH));
    assign p_rd = i_cmd.scan && (r_cnt < CW'(PENDING_DEPTH));

    assign w_match = r_wv && r_wq[WEW-1] && (r_wq[ID_W-1:0] == r_id);
    assign w_empty = r_wv && !r_wq[WEW-1];
    assign p_match = r_pv && r_pq[PEW-1] && (r_pq[PEW-2 -: ID_W] == r_id);
    assign p_empty = r_pv && !r_pq[PEW-1];

    assign o_sts.clr_done  = (r_cnt == CW'(MAXD - 1));
    assign o_sts.scan_done = (r_cnt == CW'(MAXD)) && !r_wv && !r_pv;
    assign o_sts.out_free  = !r_o_valid || i_out_ready;

    // table update decision
    always_comb begin
        w_we    = 1'b0;
        w_wa    = r_w_fidx;
        w_wd    = {1'b1, r_id};
        p_we    = 1'b0;
        p_wa    = r_p_fidx;
        p_wd    = {1'b1, r_id, r_ts};
        n_st    = ST_IGNORED;
        n_delay = '0;
        if (i_cmd.clr) begin
            w_we = r_cnt < CW'(WATCH_DEPTH);
            w_wa = r_cnt[WAW-1:0];
            w_wd = '0;
            p_we = r_cnt < CW'(PENDING_DEPTH);
            p_wa = r_cnt[PAW-1:0];
            p_wd = '0;
        end else if (i_cmd.exec) begin
            unique case (r_mode)
                MODE_ADD: begin
                    if (r_w_hit) begin
                        n_st = ST_ADDED;
                    end else if (r_w_free) begin
                        w_we = 1'b1;
                        n_st = ST_ADDED;
                    end else begin
                        n_st = ST_FULL;
                    end
                end
                MODE_REMOVE: begin
                    if (r_w_hit) begin
                        w_we = 1'b1;
                        w_wa = r_w_hidx;
                        w_wd = '0;
                        n_st = ST_REMOVED;
                    end else begin
                        n_st = ST_ABSENT;
                    end
                end
                MODE_WAKE: begin
                    if (r_w_hit) begin
                        if (r_p_hit) begin
                            p_we = 1'b1;
                            p_wa = r_p_hidx;
                            n_st = ST_WAKE;
                        end else if (r_p_free) begin
                            p_we = 1'b1;
                            n_st = ST_WAKE;
                        end else begin
                            n_st = ST_FULL;
                        end
                    end
                end
                MODE_SWITCH: begin
                    if (r_p_hit) begin
                        p_we    = 1'b1;
                        p_wa    = r_p_hidx;
                        p_wd    = '0;
                        n_st    = ST_COUNTED;  // refined against the limit later
                        n_delay = r_ts - r_p_time;
                    end
                end
                default: n_st = ST_IGNORED;
            endcase
        end
    end

    // memories
    always_ff @(posedge i_clk) begin
        if (w_we) watch_mem[w_wa] <= w_wd;
        if (w_rd) r_wq <= watch_mem[r_cnt[WAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (p_we) pend_mem[p_wa] <= p_wd;
        if (p_rd) r_pq <= pend_mem[r_cnt[PAW-1:0]];
    end

    assign counted = (r_st == ST_COUNTED) && !(r_delay > r_discard);

    // control state, configuration registers and statistics
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_wv      <= 1'b0;
            r_pv      <= 1'b0;
            r_o_valid <= 1'b0;
            r_discard <= DISCARD_RESET;
            r_late    <= LATE_RESET;
            r_sum     <= '0;
            r_samples <= '0;
            r_peak    <= '0;
            r_lates   <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DISCARD: r_discard <= i_cfg_data;
                    CFG_LATE:    r_late    <= i_cfg_data;
                    default:     r_late    <= r_late;
                endcase
            end
            r_wv <= w_rd;
            r_pv <= p_rd;
            if (i_cmd.clr || (i_cmd.scan && r_cnt != CW'(MAXD))) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.accept) begin
                r_cnt <= '0;
            end
            if (i_cmd.finish) begin
                r_o_valid <= 1'b1;
                if (counted) begin
                    r_sum     <= r_sum + r_delay;
                    r_samples <= r_samples + TS_W'(1);
                    if (r_delay > r_peak) r_peak <= r_delay;
                    if (r_delay > r_late) r_lates <= r_lates + TS_W'(1);
                end
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload: request capture, scan results, result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode   <= i_mode;
            r_id     <= i_task_id;
            r_ts     <= i_timestamp_ns;
            r_w_hit  <= 1'b0;
            r_w_free <= 1'b0;
            r_p_hit  <= 1'b0;
            r_p_free <= 1'b0;
        end else begin
            if (w_match && !r_w_hit) begin
                r_w_hit  <= 1'b1;
                r_w_hidx <= r_wra;
            end
            if (w_empty && !r_w_free) begin
                r_w_free <= 1'b1;
                r_w_fidx <= r_wra;
            end
            if (p_match && !r_p_hit) begin
                r_p_hit  <= 1'b1;
                r_p_hidx <= r_pra;
                r_p_time <= r_pq[TS_W-1:0];
            end
            if (p_empty && !r_p_free) begin
                r_p_free <= 1'b1;
                r_p_fidx <= r_pra;
            end
        end
        r_wra <= r_cnt[WAW-1:0];
        r_pra <= r_cnt[PAW-1:0];
        if (i_cmd.exec) begin
            r_st    <= n_st;
            r_delay <= n_delay;
        end
        if (i_cmd.finish) begin
            r_o_delay <= r_delay;
            if (counted) begin
                r_o_status  <= ST_COUNTED;
                r_o_sum     <= r_sum + r_delay;
                r_o_samples <= r_samples + TS_W'(1);
                r_o_peak    <= (r_delay > r_peak) ? r_delay : r_peak;
                r_o_lates   <= (r_delay > r_late) ? r_lates + TS_W'(1) : r_lates;
            end else begin
                r_o_status  <= (r_st == ST_COUNTED) ? ST_DISCARDED : r_st;
                r_o_sum     <= r_sum;
                r_o_samples <= r_samples;
                r_o_peak    <= r_peak;
                r_o_lates   <= r_lates;
            end
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_status         = r_o_status;
    assign o_delay_ns       = r_o_delay;
    assign o_total_delay_ns = r_o_sum;
    assign o_sample_count   = r_o_samples;
    assign o_peak_delay_ns  = r_o_peak;
    assign o_late_count     = r_o_lates;

endmodule

// ===== src/watched_task_queue_delay_monitor_unit.sv =====
// Watched task queue delay monitor, top level: one request in, one result out.
// Depends on wqdm_pkg, wqdm_ctrl and wqdm_dp.
//
// Requests carry a mode (watch add, watch remove, wakeup, switch in), a task id
// and a timestamp. The block keeps a watch table of WATCH_DEPTH ids and a pending
// table of PENDING_DEPTH wake times, both in single-port RAMs with a valid bit per
// entry. Each request is handled by one linear pass over both RAMs in parallel,
// one entry per cycle. Then the table update is applied and the result is loaded
// into the output register once that register is free; only then is the next
// request accepted, so the scan length is what sets the rate.
// After reset a clearing pass writes every entry invalid; no request is taken
// meanwhile, configuration writes are. Results sit in an output register, so the
// next request is accepted while the previous result waits. Config index 0 is the
// discard limit, index 1 the late threshold.
module watched_task_queue_delay_monitor_unit
    import wqdm_pkg::*;
#(
    parameter int unsigned WATCH_DEPTH   = WATCH_DEPTH_DEF,
    parameter int unsigned PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [ID_W-1:0]   i_task_id,
    input  logic [TS_W-1:0]   i_timestamp_ns,
    // configuration write port
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [TS_W-1:0]   i_cfg_data,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [ST_W-1:0]   o_status,
    output logic [TS_W-1:0]   o_delay_ns,
    output logic [TS_W-1:0]   o_total_delay_ns,
    output logic [TS_W-1:0]   o_sample_count,
    output logic [TS_W-1:0]   o_peak_delay_ns,
    output logic [TS_W-1:0]   o_late_count
);

    t_cmd cmd;
    t_sts sts;

    wqdm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    wqdm_dp #(
        .WATCH_DEPTH   (WATCH_DEPTH),
        .PENDING_DEPTH (PENDING_DEPTH)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_mode           (i_mode),
        .i_task_id        (i_task_id),
        .i_timestamp_ns   (i_timestamp_ns),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_delay_ns       (o_delay_ns),
        .o_total_delay_ns (o_total_delay_ns),
        .o_sample_count   (o_sample_count),
        .o_peak_delay_ns  (o_peak_delay_ns),
        .o_late_count     (o_late_count)
    );

endmodule

// ===== tb/watched_task_queue_delay_monitor_unit_test.sv =====
// Self-checking testbench of the watched task queue delay monitor: a directed table,
// random scheduler traffic in four idling phases, then a fill of both tables to full.
// Depends on wqdm_pkg and watched_task_queue_delay_monitor_unit.
module watched_task_queue_delay_monitor_unit_test;
    import wqdm_pkg::*;

    localparam int unsigned DEPTH       = 512;
    localparam int unsigned CYCLE_LIMIT = 3000000;
    localparam int unsigned DRAIN_WAIT  = 600;   // one full table scan plus margin
    localparam int unsigned RAND_ITEMS  = 60;    // per idling phase

    typedef struct packed {
        logic [ST_W-1:0] status;
        logic [TS_W-1:0] delay;
        logic [TS_W-1:0] total;
        logic [TS_W-1:0] count;
        logic [TS_W-1:0] peak;
        logic [TS_W-1:0] late;
    } t_result;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [TS_W-1:0]   ts;
        logic              typed;   // status and delay typed in below
        logic [ST_W-1:0]   status;
        logic [TS_W-1:0]   delay;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode = MODE_ADD;
    logic [ID_W-1:0]   i_task_id = '0;
    logic [TS_W-1:0]   i_timestamp_ns = '0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_idx = CFG_DISCARD;
    logic [TS_W-1:0]   i_cfg_data = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ST_W-1:0]   o_status;
    logic [TS_W-1:0]   o_delay_ns;
    logic [TS_W-1:0]   o_total_delay_ns;
    logic [TS_W-1:0]   o_sample_count;
    logic [TS_W-1:0]   o_peak_delay_ns;
    logic [TS_W-1:0]   o_late_count;

    watched_task_queue_delay_monitor_unit u_dut (.*);

    always #6 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Shadow copy of the monitor state
    // ---------------------------------------------------------------
    logic [TS_W-1:0] discard_limit;
    logic [TS_W-1:0] late_threshold;
    logic            watch_vld [DEPTH];
    logic [ID_W-1:0] watch_tid [DEPTH];
    logic            pend_vld  [DEPTH];
    logic [ID_W-1:0] pend_tid  [DEPTH];
    logic [TS_W-1:0] pend_wake [DEPTH];
    logic [TS_W-1:0] delay_sum, sample_total, delay_peak, late_total;

    t_result         pending_results[$];
    logic [ST_W-1:0] last_status;      // predicted status of the latest request
    int unsigned     send_idle_pct = 0;
    int unsigned     recv_stall_pct = 0;
    int unsigned     cycles = 0;
    int unsigned     requests = 0;
    int unsigned     results_seen = 0;
    int unsigned     mismatches = 0;
    int unsigned     full_hits = 0;
    logic [TS_W-1:0] clock_ns = 64'd1000;

    function automatic int find_watch(logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (watch_vld[i] && watch_tid[i] == id) return i;
        return -1;
    endfunction

    function automatic int find_pend(logic [ID_W-1:0] id);
        for (int i = 0; i < DEPTH; i++)
            if (pend_vld[i] && pend_tid[i] == id) return i;
        return -1;
    endfunction

    // Apply one request to the shadow state and return the result it produces.
    function automatic t_result predict_delay(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                              logic [TS_W-1:0] ts);
        t_result r;
        int      w, p;
        r = '0;
        r.status = ST_IGNORED;
        case (mode)
            MODE_ADD: begin
                r.status = ST_ADDED;
                if (find_watch(id) < 0) begin
                    w = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!watch_vld[i]) w = i;
                    if (w < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        watch_vld[w] = 1'b1;
                        watch_tid[w] = id;
                    end
                end
            end
            MODE_REMOVE: begin
                w = find_watch(id);
                if (w < 0) begin
                    r.status = ST_ABSENT;
                end else begin
                    watch_vld[w] = 1'b0;
                    r.status = ST_REMOVED;
                end
            end
            MODE_WAKE: begin
                if (find_watch(id) >= 0) begin
                    p = find_pend(id);
                    if (p < 0)
                        for (int i = DEPTH - 1; i >= 0; i--)
                            if (!pend_vld[i]) p = i;
                    if (p < 0) begin
                        r.status = ST_FULL;
                    end else begin
                        pend_vld[p] = 1'b1;
                        pend_tid[p] = id;
                        pend_wake[p] = ts;
                        r.status = ST_WAKE;
                    end
                end
            end
            default: begin
                p = find_pend(id);
                if (p >= 0) begin
                    r.delay = ts - pend_wake[p];   // wraps modulo 2^64
                    pend_vld[p] = 1'b0;
                    if (r.delay > discard_limit) begin
                        r.status = ST_DISCARDED;
                    end else begin
                        r.status = ST_COUNTED;
                        delay_sum += r.delay;
                        sample_total += 1;
                        if (r.delay > delay_peak) delay_peak = r.delay;
                        if (r.delay > late_threshold) late_total += 1;
                    end
                end
            end
        endcase
        r.total = delay_sum;
        r.count = sample_total;
        r.peak  = delay_peak;
        r.late  = late_total;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Request side: called and returning at a falling edge
    // ---------------------------------------------------------------
    task automatic send_request(logic [MODE_W-1:0] mode, logic [ID_W-1:0] id,
                                logic [TS_W-1:0] ts, logic typed = 1'b0,
                                logic [ST_W-1:0] st = ST_IGNORED, logic [TS_W-1:0] dly = '0);
        t_result r;
        if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_task_id      <= id;
        i_timestamp_ns <= ts;
        do @(posedge i_clk); while (!o_in_ready);
        r = predict_delay(mode, id, ts);
        if (typed) begin
            r.status = st;
            r.delay  = dly;
        end
        last_status = r.status;
        if (r.status == ST_FULL) full_hits++;
        pending_results.push_back(r);
        requests++;
        @(negedge i_clk);
    endtask

    // Lower valid, wait for every result and for the block to go quiet.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_config(logic [TS_W-1:0] discard, logic [TS_W-1:0] late);
        i_cfg_we <= 1'b1; i_cfg_idx <= CFG_DISCARD; i_cfg_data <= discard;
        @(negedge i_clk);
        i_cfg_idx <= CFG_LATE; i_cfg_data <= late;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        discard_limit  = discard;
        late_threshold = late;
        @(negedge i_clk);
    endtask

    // Scheduler-like traffic: a small id pool so watches, wakes and switches meet.
    task automatic random_traffic(int unsigned n);
        logic [MODE_W-1:0] mode;
        logic [ID_W-1:0]   id;
        logic [TS_W-1:0]   ts;
        int unsigned       pick;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            mode = pick < 20 ? MODE_ADD : pick < 30 ? MODE_REMOVE :
                   pick < 65 ? MODE_WAKE : MODE_SWITCH;
            id = ($urandom_range(0, 9) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 15));
            clock_ns += $urandom_range(0, 2500000);
            ts = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom} : clock_ns;
            send_request(mode, id, ts);
        end
    endtask

    // ---------------------------------------------------------------
    // Result side
    // ---------------------------------------------------------------
    always @(negedge i_clk)
        i_out_ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, status %0d", o_status);
            end else begin
                want = pending_results.pop_front();
                if (o_status !== want.status || o_delay_ns !== want.delay ||
                    o_total_delay_ns !== want.total || o_sample_count !== want.count ||
                    o_peak_delay_ns !== want.peak || o_late_count !== want.late) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at result %0d:", results_seen);
                        $display("  exp st %0d dly %0d tot %0d cnt %0d peak %0d late %0d",
                                 want.status, want.delay, want.total, want.count,
                                 want.peak, want.late);
                        $display("  got st %0d dly %0d tot %0d cnt %0d peak %0d late %0d",
                                 o_status, o_delay_ns, o_total_delay_ns, o_sample_count,
                                 o_peak_delay_ns, o_late_count);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, pending_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed table, default thresholds (discard 1e9, late 4e6)
    // ---------------------------------------------------------------
    localparam logic [TS_W-1:0] TS_MAX = '1;
    t_row directed[] = '{
        '{MODE_SWITCH, 22'd0,       64'd0,        1'b1, ST_IGNORED, 64'd0},  // nothing pending
        '{MODE_WAKE,   22'h3FFFFF,  TS_MAX,       1'b1, ST_IGNORED, 64'd0},  // not watched
        '{MODE_REMOVE, 22'd5,       64'd0,        1'b1, ST_ABSENT,  64'd0},
        '{MODE_ADD,    22'd0,       64'd0,        1'b1, ST_ADDED,   64'd0},
        '{MODE_ADD,    22'h3FFFFF,  TS_MAX,       1'b1, ST_ADDED,   64'd0},
        '{MODE_ADD,    22'd0,       64'd0,        1'b1, ST_ADDED,   64'd0},  // already watched
        '{MODE_WAKE,   22'd0,       64'd100,      1'b1, ST_WAKE,    64'd0},
        '{MODE_WAKE,   22'd0,       64'd200,      1'b1, ST_WAKE,    64'd0},  // overwrite
        '{MODE_SWITCH, 22'd0,       64'd5000200,  1'b1, ST_COUNTED, 64'd5000000},  // late
        '{MODE_WAKE,   22'h3FFFFF,  -64'd16,      1'b1, ST_WAKE,    64'd0},
        '{MODE_REMOVE, 22'h3FFFFF,  64'd0,        1'b1, ST_REMOVED, 64'd0},
        // pending entry outlives the watch; switch time wraps past zero
        '{MODE_SWITCH, 22'h3FFFFF,  64'd16,       1'b1, ST_COUNTED, 64'd32},
        '{MODE_WAKE,   22'd0,       64'd1000,     1'b1, ST_WAKE,    64'd0},
        '{MODE_SWITCH, 22'd0,       64'd999,      1'b1, ST_DISCARDED, TS_MAX},  // switch < wake
        '{MODE_SWITCH, 22'd0,       64'd999,      1'b1, ST_IGNORED, 64'd0},  // already consumed
        '{MODE_WAKE,   22'd0,       64'd0,        1'b0, ST_IGNORED, 64'd0},
        '{MODE_SWITCH, 22'd0,       64'd1000000000, 1'b1, ST_COUNTED, 64'd1000000000},
        '{MODE_WAKE,   22'd0,       64'd0,        1'b0, ST_IGNORED, 64'd0},
        '{MODE_SWITCH, 22'd0,       64'd1000000001, 1'b1, ST_DISCARDED, 64'd1000000001},
        '{MODE_WAKE,   22'd0,       64'd7,        1'b0, ST_IGNORED, 64'd0},
        '{MODE_SWITCH, 22'd0,       64'd7,        1'b1, ST_COUNTED, 64'd0},
        '{MODE_WAKE,   22'd0,       64'd0,        1'b0, ST_IGNORED, 64'd0},
        '{MODE_SWITCH, 22'd0,       64'd4000000,  1'b0, ST_IGNORED, 64'd0}   // at late edge
    };

    initial begin
        logic [ID_W-1:0] drain_ids[$];
        int              w;
        discard_limit  = DISCARD_RESET;
        late_threshold = LATE_RESET;
        for (int i = 0; i < DEPTH; i++) begin
            watch_vld[i] = 1'b0; watch_tid[i] = '0;
            pend_vld[i]  = 1'b0; pend_tid[i]  = '0; pend_wake[i] = '0;
        end
        delay_sum = '0; sample_total = '0; delay_peak = '0; late_total = '0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed[k])
            send_request(directed[k].mode, directed[k].id, directed[k].ts,
                         directed[k].typed, directed[k].status, directed[k].delay);

        // four idling phases, each with its own thresholds, extremes included
        for (int ph = 0; ph < 4; ph++) begin
            settle();
            case (ph)
                0: write_config(DISCARD_RESET, LATE_RESET);
                1: write_config(TS_MAX, '0);
                2: write_config('0, TS_MAX);
                default: write_config(64'd1000000 + $urandom_range(0, 1 << 30),
                                      64'($urandom_range(0, 3000000)));
            endcase
            send_idle_pct  = (ph == 1) ? 63 : (ph == 3) ? 7 : 0;
            recv_stall_pct = (ph == 2) ? 63 : (ph == 3) ? 7 : 0;
            random_traffic(RAND_ITEMS);
        end

        // Fill the watch set until it reports full, then wake watched ids until
        // the pending table is full.
        settle();
        write_config(64'd2000000000, 64'd1000000);
        send_idle_pct = 7;
        recv_stall_pct = 7;
        for (int k = 0; k <= DEPTH + 1; k++) begin
            send_request(MODE_ADD, ID_W'(22'h100000 + k), clock_ns);
            if (last_status == ST_FULL) break;
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (watch_vld[i]) begin
                clock_ns += $urandom_range(0, 3000000);
                send_request(MODE_WAKE, watch_tid[i], clock_ns);
                if (last_status == ST_FULL) break;
            end
        end
        // free a watch slot, then a fresh watched id finds the pending table full
        w = find_watch(22'h100000);
        if (w >= 0) send_request(MODE_REMOVE, 22'h100000, clock_ns);
        send_request(MODE_ADD, 22'h3ABCDE, clock_ns);
        send_request(MODE_WAKE, 22'h3ABCDE, clock_ns);

        // drain part of the pending table with switch-ins
        for (int i = 0; i < DEPTH; i++)
            if (pend_vld[i] && drain_ids.size() < 256) drain_ids.push_back(pend_tid[i]);
        foreach (drain_ids[k]) begin
            clock_ns += $urandom_range(0, 200000);
            send_request(MODE_SWITCH, drain_ids[k], clock_ns);
        end

        settle();
        $display("%0d requests and %0d results in %0d cycles, %0d table-full results,",
                 requests, results_seen, cycles, full_hits);
        $display("four idling phases and five threshold settings; %0d mismatches",
                 mismatches);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== watched_task_queue_delay_monitor_unit.f =====
src/wqdm_pkg.sv
src/wqdm_ctrl.sv
src/wqdm_dp.sv
src/watched_task_queue_delay_monitor_unit.sv
tb/watched_task_queue_delay_monitor_unit_test.sv
